/* design/edfs_pkg.sv */
// ----------------------------------------------------------------------------
// edfs_pkg: shared types and codes for the EDF scheduler
// Field widths, operation and result codes, the task record and the
// scan summary passed between the scan unit and the sequencer.
// ----------------------------------------------------------------------------
package edfs_pkg;

	localparam int TIME_W = 32;
	localparam int COMP_W = 16;
	localparam int FUNC_W = 2;
	localparam int KIND_W = 3;
	localparam int SLOT_W = 5;

	localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

	localparam logic [KIND_W-1:0] KIND_LOADED = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RAN    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_IDLE   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DONE   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FULL   = 3'd4;

	typedef logic [TIME_W-1:0] tstamp_t;
	typedef logic [COMP_W-1:0] units_t;

	localparam tstamp_t TIME_MAX = '1;

	typedef struct packed {
		tstamp_t arrival;
		units_t  compute;
		units_t  remaining;
		tstamp_t deadline;
		tstamp_t start_at;
		logic    started;
	} task_rec_t;

	typedef struct packed {
		logic      have;
		logic      pend;
		tstamp_t   next_arrival;
		task_rec_t best;
	} scan_res_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] task_slot;
		tstamp_t           time_now;
		logic              finished;
		tstamp_t           start_time;
		tstamp_t           finish_time;
		tstamp_t           turnaround;
		tstamp_t           waiting;
		logic              deadline_missed;
	} result_t;

endpackage

/* design/edfs_ifs.sv */
// ----------------------------------------------------------------------------
// edfs_ifs: command and response channels of the EDF scheduler
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface edfs_cmd_if;
	import edfs_pkg::*;

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	tstamp_t           arrival_time;
	units_t            compute_time;
	tstamp_t           deadline;

	modport source (output valid, func, arrival_time, compute_time, deadline, input ready);
	modport sink   (input valid, func, arrival_time, compute_time, deadline, output ready);
endinterface

interface edfs_rsp_if;
	import edfs_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [SLOT_W-1:0] task_slot;
	tstamp_t           time_now;
	logic              finished;
	tstamp_t           start_time;
	tstamp_t           finish_time;
	tstamp_t           turnaround;
	tstamp_t           waiting;
	logic              deadline_missed;

	modport source (output valid, kind, task_slot, time_now, finished, start_time,
		finish_time, turnaround, waiting, deadline_missed, input ready);
	modport sink   (input valid, kind, task_slot, time_now, finished, start_time,
		finish_time, turnaround, waiting, deadline_missed, output ready);
endinterface

/* design/edfs_task_mem.sv */
// ----------------------------------------------------------------------------
// edfs_task_mem: task table storage
// One write port and one registered read port; entries hold whole task records.
// ----------------------------------------------------------------------------
module edfs_task_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  edfs_pkg::task_rec_t wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output edfs_pkg::task_rec_t rd_data
);
	import edfs_pkg::*;

	task_rec_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* design/edfs_scan_unit.sv */
// ----------------------------------------------------------------------------
// edfs_scan_unit: shared compare unit for the slot scan
// Takes one task record a cycle and keeps the earliest ready deadline and
// the earliest pending arrival seen since the last start pulse.
// ----------------------------------------------------------------------------
module edfs_scan_unit #(
	parameter int AW = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                valid,
	input  logic [AW-1:0]       slot,
	input  edfs_pkg::task_rec_t rec,
	input  edfs_pkg::tstamp_t   now,
	output edfs_pkg::scan_res_t res,
	output logic [AW-1:0]       best_slot
);
	import edfs_pkg::*;

	logic      have_q;
	logic      pend_q;
	tstamp_t   next_q;
	task_rec_t best_q;
	logic [AW-1:0] slot_q;

	logic is_live;
	logic is_ready;
	logic better;
	logic earlier;

	assign is_live  = rec.remaining != '0;
	assign is_ready = is_live && (rec.arrival <= now);
	// strict compares keep the lower slot on a full tie
	assign better   = !have_q || (rec.deadline < best_q.deadline) ||
		((rec.deadline == best_q.deadline) && (rec.arrival < best_q.arrival));
	assign earlier  = !pend_q || (rec.arrival < next_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			pend_q <= 1'b0;
		end else if (start) begin
			have_q <= 1'b0;
			pend_q <= 1'b0;
		end else if (valid) begin
			if (is_ready && better) begin
				have_q <= 1'b1;
			end
			if (is_live && earlier) begin
				pend_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid && !start) begin
			if (is_ready && better) begin
				best_q <= rec;
				slot_q <= slot;
			end
			if (is_live && earlier) begin
				next_q <= rec.arrival;
			end
		end
	end

	assign res.have         = have_q;
	assign res.pend         = pend_q;
	assign res.next_arrival = next_q;
	assign res.best         = best_q;
	assign best_slot        = slot_q;

endmodule

/* design/edf_preemptive_scheduler.sv */
// ----------------------------------------------------------------------------
// edf_preemptive_scheduler: preemptive earliest-deadline-first scheduler
// Holds a task table, loads tasks, steps the schedule one time unit per
// command and reports finish statistics.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake     carries
//   -------  ---  ------------  ----------------------------------------------
//   cmd      in   valid/ready   func, arrival_time, compute_time, deadline
//   rsp      out  valid/ready   kind, task_slot, time_now, finished, stats
//
// Add and clear go from the accepting state to the final state and then to the
// response register; a step scans the table, runs or idles in the exec state,
// and passes through the stats and wait states when the task run finishes.
// The scan reads one slot of the task table per cycle through its single
// read port into the shared compare unit.
// Reset empties the table and zeroes the clock; the table contents are not
// cleared, as only loaded slots are ever read.
// A stalled response holds in its output register; the next command is taken
// meanwhile and waits in its final state until that register frees.
// Command code three is taken and dropped without a response.
//
module edf_preemptive_scheduler #(
	parameter int MAX_TASKS = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	edfs_cmd_if.sink   cmd,
	edfs_rsp_if.source rsp
);
	import edfs_pkg::*;

	localparam int AW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_TASKS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EXEC,
		ST_STATS,
		ST_WAIT,
		ST_OUT
	} state_t;

	state_t  state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] issue_q;
	tstamp_t now_q;
	logic    rd_valid_s1;
	logic [AW-1:0] rd_slot_s1;
	result_t res_q;
	result_t out_q;
	logic    out_valid_q;

	logic      cmd_acc;
	logic      scan_start;
	logic      scan_issue;
	logic      scan_done;
	logic      out_load;
	logic      mem_we;
	logic [AW-1:0] mem_waddr;
	task_rec_t mem_wdata;
	task_rec_t mem_rdata;
	task_rec_t add_rec;
	task_rec_t run_rec;
	result_t   idle_res;
	scan_res_t scan_res;
	logic [AW-1:0] best_slot;
	tstamp_t   now_inc;
	logic [AW+SLOT_W-1:0] add_slot_w;
	logic [AW+SLOT_W-1:0] run_slot_w;

	assign cmd.ready  = (state_q == ST_IDLE);
	assign cmd_acc    = cmd.valid && cmd.ready;
	assign scan_start = cmd_acc && (cmd.func == FUNC_STEP);
	assign scan_issue = (state_q == ST_SCAN) && (issue_q < count_q);
	assign scan_done  = (state_q == ST_SCAN) && !scan_issue && !rd_valid_s1;
	assign out_load   = (state_q == ST_OUT) && (!out_valid_q || rsp.ready);
	assign now_inc    = (now_q == TIME_MAX) ? now_q : now_q + TIME_W'(1);

	// Widen slot numbers, then keep the low bits for the report.
	assign add_slot_w = {SLOT_W'(0), count_q[AW-1:0]};
	assign run_slot_w = {SLOT_W'(0), best_slot};

	always_comb begin
		add_rec           = '0;
		add_rec.arrival   = cmd.arrival_time;
		add_rec.compute   = cmd.compute_time;
		add_rec.remaining = cmd.compute_time;
		add_rec.deadline  = cmd.deadline;

		// Take one unit off the chosen task; stamp its start on the first run.
		run_rec           = scan_res.best;
		run_rec.remaining = scan_res.best.remaining - COMP_W'(1);
		if (!scan_res.best.started) begin
			run_rec.started  = 1'b1;
			run_rec.start_at = now_q;
		end
	end

	// Response of a command taken in the idle state; a step fills in the rest
	// once its scan is over.
	always_comb begin
		idle_res          = '0;
		idle_res.time_now = now_q;
		unique case (cmd.func)
			FUNC_ADD: begin
				if (count_q == COUNT_MAX) begin
					idle_res.kind = KIND_FULL;
				end else begin
					idle_res.kind      = KIND_LOADED;
					idle_res.task_slot = add_slot_w[SLOT_W-1:0];
				end
			end
			FUNC_CLEAR: begin
				idle_res.kind     = KIND_DONE;
				idle_res.time_now = '0;
			end
			default: begin
				idle_res.kind = KIND_LOADED;
			end
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = add_rec;
		if (cmd_acc && (cmd.func == FUNC_ADD) && (count_q != COUNT_MAX)) begin
			mem_we = 1'b1;
		end else if ((state_q == ST_EXEC) && scan_res.have) begin
			mem_we    = 1'b1;
			mem_waddr = best_slot;
			mem_wdata = run_rec;
		end
	end

	edfs_task_mem #(
		.DEPTH (MAX_TASKS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (scan_issue),
		.rd_addr (issue_q[AW-1:0]),
		.rd_data (mem_rdata)
	);

	edfs_scan_unit #(
		.AW (AW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_start),
		.valid     (rd_valid_s1),
		.slot      (rd_slot_s1),
		.rec       (mem_rdata),
		.now       (now_q),
		.res       (scan_res),
		.best_slot (best_slot)
	);

	// Sequencer: state, counters, clock and the response registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			issue_q     <= '0;
			now_q       <= '0;
			rd_valid_s1 <= 1'b0;
			rd_slot_s1  <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Load the next response, or drop the current one once the sink takes it.
			if (out_load) begin
				out_q       <= res_q;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			rd_valid_s1 <= scan_issue;
			rd_slot_s1  <= issue_q[AW-1:0];

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						res_q <= idle_res;
						unique case (cmd.func)
							FUNC_ADD: begin
								if (count_q != COUNT_MAX) begin
									count_q <= count_q + CW'(1);
								end
								state_q <= ST_OUT;
							end
							FUNC_STEP: begin
								issue_q <= '0;
								state_q <= ST_SCAN;
							end
							FUNC_CLEAR: begin
								count_q <= '0;
								now_q   <= '0;
								state_q <= ST_OUT;
							end
							FUNC_NONE: begin
								state_q <= ST_IDLE;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					// Issue one slot a cycle; finish once the last read is compared.
					if (scan_issue) begin
						issue_q <= issue_q + CW'(1);
					end
					if (scan_done) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (scan_res.have) begin
						now_q            <= now_inc;
						res_q.kind       <= KIND_RAN;
						res_q.task_slot  <= run_slot_w[SLOT_W-1:0];
						res_q.time_now   <= now_inc;
						if (scan_res.best.remaining == COMP_W'(1)) begin
							res_q.finished    <= 1'b1;
							res_q.start_time  <= scan_res.best.started ?
								scan_res.best.start_at : now_q;
							res_q.finish_time <= now_inc;
							state_q           <= ST_STATS;
						end else begin
							state_q <= ST_OUT;
						end
					end else if (scan_res.pend) begin
						now_q          <= scan_res.next_arrival;
						res_q.kind     <= KIND_IDLE;
						res_q.time_now <= scan_res.next_arrival;
						state_q        <= ST_OUT;
					end else begin
						res_q.kind <= KIND_DONE;
						state_q    <= ST_OUT;
					end
				end
				ST_STATS: begin
					res_q.turnaround <= now_q - scan_res.best.arrival;
					state_q          <= ST_WAIT;
				end
				ST_WAIT: begin
					// Floor waiting at zero when saturation shortens the turnaround.
					res_q.waiting <= (res_q.turnaround >= TIME_W'(scan_res.best.compute)) ?
						res_q.turnaround - TIME_W'(scan_res.best.compute) : '0;
					res_q.deadline_missed <= now_q > scan_res.best.deadline;
					state_q               <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.kind            = out_q.kind;
	assign rsp.task_slot       = out_q.task_slot;
	assign rsp.time_now        = out_q.time_now;
	assign rsp.finished        = out_q.finished;
	assign rsp.start_time      = out_q.start_time;
	assign rsp.finish_time     = out_q.finish_time;
	assign rsp.turnaround      = out_q.turnaround;
	assign rsp.waiting         = out_q.waiting;
	assign rsp.deadline_missed = out_q.deadline_missed;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_MAX)
		else $error("task count beyond table size");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_acc && (cmd.func == FUNC_CLEAR)) |=> (count_q == '0 && now_q == '0))
		else $error("clear left table or clock set");

	a_time_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_acc && (cmd.func == FUNC_CLEAR)) |=> (now_q >= $past(now_q)))
		else $error("clock moved backwards");

	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_IDLE || state_q == ST_EXEC))
		else $error("table written outside add or run");

	a_rsp_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("response raised outside final state");

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for edf_preemptive_scheduler
// Feeds add, step, clear and dropped commands with random gaps on both channels. It
// keeps its own copy of the EDF schedule to predict every response, then
// compares each response field by field, oldest prediction first.
// ----------------------------------------------------------------------------
module testbench;
	import edfs_pkg::*;

	localparam int NUM_SLOTS  = 32;
	localparam int ITEM_GOAL  = 1600;  // items that produce a response
	localparam int QUIET_MAX  = 3000;  // cycles with no item moved on either side
	localparam int CALM_TAIL  = 150;   // no gaps once the backlog is this short
	localparam int SETTLE_CYC = 80;    // cycles of settling after the last response

	typedef struct {
		logic [FUNC_W-1:0] func;
		tstamp_t           arrival;
		units_t            compute;
		tstamp_t           deadline;
		bit                drain_first;  // hold until every response is back
	} sched_cmd_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	edfs_cmd_if cmd_ch ();
	edfs_rsp_if rsp_ch ();

	edf_preemptive_scheduler #(.MAX_TASKS(NUM_SLOTS)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	sched_cmd_t cmd_backlog[$];   // commands not yet presented
	result_t    due_results[$];   // predicted responses, oldest first
	int         error_count;
	int         resp_count;
	int         quiet_cycles;
	int         items_queued;
	int         items_taken;
	int         useful_items;
	int         send_gap;
	int         sink_gap;
	bit         cmd_took;         // command moved at the last rising edge

	// Predicted schedule: task table, fill level and clock
	tstamp_t slot_arrival  [NUM_SLOTS];
	units_t  slot_compute  [NUM_SLOTS];
	units_t  slot_left     [NUM_SLOTS];
	tstamp_t slot_deadline [NUM_SLOTS];
	tstamp_t slot_start    [NUM_SLOTS];
	bit      slot_started  [NUM_SLOTS];
	int      slot_count;
	tstamp_t sched_now = '0;

	// Clock, and every block input at a known value from time zero
	initial begin
		cmd_ch.valid        = 1'b0;
		cmd_ch.func         = FUNC_NONE;
		cmd_ch.arrival_time = '0;
		cmd_ch.compute_time = '0;
		cmd_ch.deadline     = '0;
		rsp_ch.ready        = 1'b0;
		forever #1 clk = ~clk;
	end

	// Work out the response of one accepted command and advance the schedule.
	// Unused command codes change nothing and answer nothing.
	task automatic edf_predict(input sched_cmd_t c);
		result_t r;
		bit      have;
		bit      pend;
		int      pick;
		int      i;
		tstamp_t next_arr;
		tstamp_t span;
		if (c.func == FUNC_NONE)
			return;
		r = '0;
		case (c.func)
		FUNC_ADD: begin
			// a full table leaves everything alone and reports slot zero
			r.kind = KIND_FULL;
			if (slot_count < NUM_SLOTS) begin
				slot_arrival[slot_count]  = c.arrival;
				slot_compute[slot_count]  = c.compute;
				slot_left[slot_count]     = c.compute;
				slot_deadline[slot_count] = c.deadline;
				slot_started[slot_count]  = 1'b0;
				r.kind      = KIND_LOADED;
				r.task_slot = slot_count[SLOT_W-1:0];
				slot_count++;
			end
			r.time_now = sched_now;
		end
		FUNC_STEP: begin
			have = 1'b0;
			pend = 1'b0;
			pick = 0;
			next_arr = '0;
			// earliest deadline among arrived, unfinished tasks; ties to the
			// earlier arrival, then to the lower slot (strict compares keep it)
			for (i = 0; i < slot_count; i++) begin
				if (slot_left[i] != 0 && slot_arrival[i] <= sched_now) begin
					if (!have || slot_deadline[i] < slot_deadline[pick] ||
						(slot_deadline[i] == slot_deadline[pick] &&
						 slot_arrival[i] < slot_arrival[pick])) begin
						pick = i;
						have = 1'b1;
					end
				end
			end
			if (!have) begin
				// nothing ready: jump to the earliest pending arrival, if any
				for (i = 0; i < slot_count; i++) begin
					if (slot_left[i] != 0 && (!pend || slot_arrival[i] < next_arr)) begin
						next_arr = slot_arrival[i];
						pend = 1'b1;
					end
				end
				if (pend) begin
					sched_now = next_arr;
					r.kind = KIND_IDLE;
				end else begin
					r.kind = KIND_DONE;
				end
				r.time_now = sched_now;
			end else begin
				if (!slot_started[pick]) begin
					slot_started[pick] = 1'b1;
					slot_start[pick]   = sched_now;
				end
				slot_left[pick] = slot_left[pick] - 1'b1;
				// the clock sticks at its maximum
				if (sched_now != TIME_MAX)
					sched_now = sched_now + 1'b1;
				r.kind      = KIND_RAN;
				r.task_slot = pick[SLOT_W-1:0];
				r.time_now  = sched_now;
				if (slot_left[pick] == 0) begin
					span = sched_now - slot_arrival[pick];
					r.finished        = 1'b1;
					r.start_time      = slot_start[pick];
					r.finish_time     = sched_now;
					r.turnaround      = span;
					// a saturated clock can make the turnaround shorter than the work
					r.waiting         = (span >= slot_compute[pick]) ?
						span - slot_compute[pick] : '0;
					r.deadline_missed = sched_now > slot_deadline[pick];
				end
			end
		end
		default: begin
			// clear: empty table, clock back to zero
			slot_count = 0;
			sched_now  = '0;
			foreach (slot_started[j])
				slot_started[j] = 1'b0;
			r.kind = KIND_DONE;
		end
		endcase
		due_results.push_back(r);
	endtask

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_error($sformatf("response %0d %s: got 0x%0h, expected 0x%0h",
				resp_count, name, got, want));
	endtask

	task automatic check_response();
		result_t want;
		if (due_results.size() == 0) begin
			report_error($sformatf("response %0d (kind %0d) with nothing expected",
				resp_count, rsp_ch.kind));
		end else begin
			want = due_results.pop_front();
			check_field("kind", rsp_ch.kind, want.kind);
			check_field("task_slot", rsp_ch.task_slot, want.task_slot);
			check_field("time_now", rsp_ch.time_now, want.time_now);
			check_field("finished", rsp_ch.finished, want.finished);
			check_field("start_time", rsp_ch.start_time, want.start_time);
			check_field("finish_time", rsp_ch.finish_time, want.finish_time);
			check_field("turnaround", rsp_ch.turnaround, want.turnaround);
			check_field("waiting", rsp_ch.waiting, want.waiting);
			check_field("deadline_missed", rsp_ch.deadline_missed, want.deadline_missed);
		end
		resp_count++;
	endtask

	// Gaps only while the backlog is long, and not in every stretch of it
	function automatic bit idle_on();
		return cmd_backlog.size() >= CALM_TAIL && (cmd_backlog.size() / 200) % 3 != 1;
	endfunction

	task automatic push_cmd(input logic [FUNC_W-1:0] f, input tstamp_t a,
		input units_t c, input tstamp_t d, input bit drain);
		sched_cmd_t item;
		item.func        = f;
		item.arrival     = a;
		item.compute     = c;
		item.deadline    = d;
		item.drain_first = drain;
		cmd_backlog.push_back(item);
		items_queued++;
		if (f != FUNC_NONE)
			useful_items++;
	endtask

	// Monitor: check responses, predict from accepted commands, watch for a hang
	always @(posedge clk) begin : monitor
		sched_cmd_t seen;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				check_response();
			if (cmd_ch.valid && cmd_ch.ready) begin
				seen.func        = cmd_ch.func;
				seen.arrival     = cmd_ch.arrival_time;
				seen.compute     = cmd_ch.compute_time;
				seen.deadline    = cmd_ch.deadline;
				seen.drain_first = 1'b0;
				edf_predict(seen);
				items_taken++;
			end
			cmd_took <= cmd_ch.valid && cmd_ch.ready;
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_MAX) begin
				$display("timeout: no item moved for %0d cycles", QUIET_MAX);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Command driver: hold an item until taken, then present the next one or
	// idle for a short burst
	always @(negedge clk) begin : cmd_driver
		sched_cmd_t nxt;
		bit         go;
		if (arst_n && !(cmd_ch.valid && !cmd_took)) begin
			go = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (cmd_backlog.size() != 0 &&
				!(cmd_backlog[0].drain_first && due_results.size() != 0)) begin
				if (idle_on() && $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(0, 2);
				end else begin
					nxt = cmd_backlog.pop_front();
					go  = 1'b1;
				end
			end
			cmd_ch.valid <= go;
			if (go) begin
				cmd_ch.func         <= nxt.func;
				cmd_ch.arrival_time <= nxt.arrival;
				cmd_ch.compute_time <= nxt.compute;
				cmd_ch.deadline     <= nxt.deadline;
			end
		end
	end

	// Response sink: stall in random bursts while the backlog is long
	always @(negedge clk) begin : rsp_sink
		if (arst_n) begin
			if (sink_gap > 0) begin
				sink_gap--;
				rsp_ch.ready <= 1'b0;
			end else if (idle_on() && $urandom_range(0, 4) == 0) begin
				sink_gap = $urandom_range(0, 2);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		tstamp_t base;
		tstamp_t arr;
		tstamp_t dl;
		units_t  comp;
		int      n;
		int      k;
		int      steps;
		int      budget;
		int      spread;
		bit      first_set;

		// Directed: step on an empty table, a dropped code, field extremes
		push_cmd(FUNC_STEP, '0, '0, '0, 1'b0);
		push_cmd(FUNC_NONE, TIME_MAX, '1, TIME_MAX, 1'b0);
		// deadline zero, missed on finish
		push_cmd(FUNC_ADD, '0, 16'd1, '0, 1'b0);
		// same deadline and arrival as slot 0: lower slot goes first
		push_cmd(FUNC_ADD, '0, 16'd2, '0, 1'b0);
		// same deadline, later arrival than the next one: loses the tie
		push_cmd(FUNC_ADD, 32'd1, 16'd1, 32'd10, 1'b0);
		push_cmd(FUNC_ADD, '0, 16'd1, 32'd10, 1'b0);
		// no work at all: never runs, never reports a finish
		push_cmd(FUNC_ADD, 32'd3, '0, 32'd5, 1'b0);
		// arrives at the very end of time, longest work
		push_cmd(FUNC_ADD, TIME_MAX, '1, TIME_MAX, 1'b0);
		// run the lot, idle-jump to the top and run saturated
		repeat (9)
			push_cmd(FUNC_STEP, '0, '0, '0, 1'b0);
		// drain everything before clearing
		push_cmd(FUNC_CLEAR, '0, '0, '0, 1'b1);
		// finish under a saturated clock: waiting floors at zero
		push_cmd(FUNC_ADD, TIME_MAX - 32'd2, 16'd5, TIME_MAX - 32'd1, 1'b0);
		repeat (7)
			push_cmd(FUNC_STEP, '0, '0, '0, 1'b0);

		// Random task sets, each stepped until it should be done; the first
		// one overfills the table
		first_set = 1'b1;
		while (useful_items < ITEM_GOAL) begin
			if (first_set || $urandom_range(0, 7) != 0)
				push_cmd(FUNC_CLEAR, '0, '0, '0, $urandom_range(0, 5) == 0);
			if (first_set)
				n = NUM_SLOTS + 2;
			else if ($urandom_range(0, 9) == 0)
				n = $urandom_range(28, NUM_SLOTS + 2);
			else
				n = $urandom_range(1, 10);
			case ($urandom_range(0, 3))
			0: base = '0;
			1: base = $urandom_range(0, 200);
			2: base = $urandom;
			default: base = TIME_MAX - $urandom_range(0, 300);
			endcase
			spread = ($urandom_range(0, 3) == 0) ? 0 : 30;
			budget = 0;
			for (k = 0; k < n; k++) begin
				arr = base + $urandom_range(0, spread);
				if ($urandom_range(0, 19) == 0)
					comp = units_t'($urandom_range(1, 65535));
				else
					comp = units_t'($urandom_range(1, 4));
				case ($urandom_range(0, 9))
				0: dl = $urandom;
				1, 2, 3: dl = base + 8 * $urandom_range(1, 4);  // shared deadlines
				default: dl = arr + comp + $urandom_range(0, 40) - 10;
				endcase
				push_cmd(FUNC_ADD, arr, comp, dl, 1'b0);
				budget += (comp > 6) ? 6 : comp;
			end
			steps = budget + n + $urandom_range(0, 3);
			for (k = 0; k < steps; k++) begin
				// sprinkle dropped codes and late arrivals among the steps
				case ($urandom_range(0, 49))
				0: push_cmd(FUNC_NONE, $urandom, units_t'($urandom), $urandom, 1'b0);
				1: push_cmd(FUNC_ADD, base + $urandom_range(0, 60),
					units_t'($urandom_range(1, 3)), base + $urandom_range(0, 60), 1'b0);
				default: ;
				endcase
				push_cmd(FUNC_STEP, '0, '0, '0, 1'b0);
			end
			first_set = 1'b0;
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wait for every command to go in and every response to come back
		while (items_taken != items_queued || due_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
